@@ hw/rtl/column_vote_threshold_filter_macros.svh @@
// Assertion macros used by the checker of the column vote filter.
`ifndef COLUMN_VOTE_THRESHOLD_FILTER_MACROS_SVH
`define COLUMN_VOTE_THRESHOLD_FILTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CVTF_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cvtf check failed");

// Consequent must hold in the cycle after the antecedent.
`define CVTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cvtf check failed");

`endif

@@ hw/rtl/cvtf_pkg.sv @@
// Types and constants of the column vote threshold filter.
package cvtf_pkg;

   localparam int COLUMN_TOTAL  = 64;
   localparam int COUNT_BITS    = 16;
   localparam int ROW_BITS      = 64;
   localparam int COL_IDX_BITS  = 6;
   localparam int CFG_BITS      = 16;
   localparam int COLS_REG_BITS = 7;
   localparam int CMP_BITS      = 32;
   localparam int ADDR_BITS     = 4;
   localparam int DATA_BITS     = 32;
   localparam int REG_IDX_BITS  = ADDR_BITS - 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   localparam logic [REG_IDX_BITS-1:0] REG_MIN_DISCOVERED = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_MAX_MISSING    = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_COLUMNS_IN_USE = REG_IDX_BITS'(2);

   localparam logic [CFG_BITS-1:0]      RST_MIN_DISCOVERED = CFG_BITS'(1);
   localparam logic [CFG_BITS-1:0]      RST_MAX_MISSING    = CFG_BITS'(0);
   localparam logic [COLS_REG_BITS-1:0] RST_COLUMNS_IN_USE = COLS_REG_BITS'(64);

   typedef struct packed {
      logic [ROW_BITS-1:0] row_bits;
      logic                first_row;
   } req_item_type;

   typedef struct packed {
      logic [COL_IDX_BITS-1:0] column_index;
      logic                    last_of_row;
   } rsp_item_type;

   // Request after column masking, as it sits in the queue.
   typedef struct packed {
      logic [COLUMN_TOTAL-1:0] bits;
      logic                    first_row;
   } queue_item_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]      min_discovered;
      logic [CFG_BITS-1:0]      max_missing;
      logic [COLS_REG_BITS-1:0] columns_in_use;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic [COLUMN_TOTAL-1:0] mask;
   } emit_load_type;

endpackage

@@ hw/rtl/column_vote_threshold_filter.sv @@
// Column vote threshold filter.
// A row passes the counting back end in the steps pop, count, retire and hand-off;
// the next row waits in hand-off while the serializer drains the previous row, one
// column per cycle unless rsp_ready stalls it.
// Synchronous active-high reset: counters zero, all columns active, registers at defaults;
// usable in the cycle after reset is released.
module column_vote_threshold_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cvtf_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cvtf_pkg::rsp_item_type              rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cvtf_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [cvtf_pkg::DATA_BITS-1:0]      pwdata,
   output logic [cvtf_pkg::DATA_BITS-1:0]      prdata,
   output logic                                pready
);

   cvtf_pkg::cfg_type                       cfg_ff;
   cvtf_pkg::cfg_type                       cfg_in;
   logic [cvtf_pkg::REG_IDX_BITS-1:0]       reg_idx;
   logic                                    csr_write;
   logic                                    push_valid;
   logic                                    push_ready;
   cvtf_pkg::queue_item_type                push_item;
   logic                                    pop_valid;
   logic                                    pop;
   cvtf_pkg::queue_item_type                pop_item;
   logic                                    emit_ready;
   cvtf_pkg::emit_load_type                 emit_load;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[cvtf_pkg::ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (reg_idx)
         cvtf_pkg::REG_MIN_DISCOVERED: begin
            prdata = {{(cvtf_pkg::DATA_BITS-cvtf_pkg::CFG_BITS){1'b0}},
                      cfg_ff.min_discovered};
            if (csr_write) begin
               cfg_in.min_discovered = pwdata[cvtf_pkg::CFG_BITS-1:0];
            end
         end
         cvtf_pkg::REG_MAX_MISSING: begin
            prdata = {{(cvtf_pkg::DATA_BITS-cvtf_pkg::CFG_BITS){1'b0}},
                      cfg_ff.max_missing};
            if (csr_write) begin
               cfg_in.max_missing = pwdata[cvtf_pkg::CFG_BITS-1:0];
            end
         end
         cvtf_pkg::REG_COLUMNS_IN_USE: begin
            prdata = {{(cvtf_pkg::DATA_BITS-cvtf_pkg::COLS_REG_BITS){1'b0}},
                      cfg_ff.columns_in_use};
            if (csr_write) begin
               cfg_in.columns_in_use = pwdata[cvtf_pkg::COLS_REG_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_discovered <= cvtf_pkg::RST_MIN_DISCOVERED;
         cfg_ff.max_missing    <= cvtf_pkg::RST_MAX_MISSING;
         cfg_ff.columns_in_use <= cvtf_pkg::RST_COLUMNS_IN_USE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cvtf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .columns_in_use (cfg_ff.columns_in_use),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   cvtf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   cvtf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop            (pop),
      .pop_item       (pop_item),
      .min_discovered (cfg_ff.min_discovered),
      .max_missing    (cfg_ff.max_missing),
      .emit_ready     (emit_ready),
      .emit_load      (emit_load)
   );

   cvtf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .emit_load  (emit_load),
      .emit_ready (emit_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hw/rtl/cvtf_front.sv @@
// Front end: takes requests, masks unused columns, pushes into the queue.
module cvtf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cvtf_pkg::req_item_type  req_data,
   input  logic [cvtf_pkg::COLS_REG_BITS-1:0] columns_in_use,
   output logic                    push_valid,
   input  logic                    push_ready,
   output cvtf_pkg::queue_item_type push_item
);

   logic                     valid_ff;
   logic                     valid_in;
   cvtf_pkg::queue_item_type item_ff;
   cvtf_pkg::queue_item_type item_in;
   logic                     take;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      item_in.first_row = req_data.first_row;
      for (int j = 0; j < cvtf_pkg::COLUMN_TOTAL; j++) begin
         item_in.bits[j] = req_data.row_bits[j] &&
            (cvtf_pkg::COLS_REG_BITS'(j) < columns_in_use);
      end
      valid_in = take || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/cvtf_queue.sv @@
// Short queue between the front end and the counting back end.
module cvtf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  cvtf_pkg::queue_item_type push_item,
   output logic                     pop_valid,
   input  logic                     pop,
   output cvtf_pkg::queue_item_type pop_item
);

   cvtf_pkg::queue_item_type         entries_ff [cvtf_pkg::QUEUE_DEPTH];
   logic [cvtf_pkg::QPTR_BITS-1:0]   wr_ptr_ff;
   logic [cvtf_pkg::QPTR_BITS-1:0]   wr_ptr_in;
   logic [cvtf_pkg::QPTR_BITS-1:0]   rd_ptr_ff;
   logic [cvtf_pkg::QPTR_BITS-1:0]   rd_ptr_in;
   logic [cvtf_pkg::QPTR_BITS:0]     count_ff;
   logic [cvtf_pkg::QPTR_BITS:0]     count_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = count_ff != (cvtf_pkg::QPTR_BITS+1)'(cvtf_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/cvtf_back.sv @@
// Back end: per-column hit counters, reporting and early retirement.
module cvtf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop,
   input  cvtf_pkg::queue_item_type      pop_item,
   input  logic [cvtf_pkg::CFG_BITS-1:0] min_discovered,
   input  logic [cvtf_pkg::CFG_BITS-1:0] max_missing,
   input  logic                          emit_ready,
   output cvtf_pkg::emit_load_type       emit_load
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COUNT,
      S_RETIRE,
      S_HAND
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   cvtf_pkg::queue_item_type           cur_ff;
   cvtf_pkg::queue_item_type           cur_in;
   logic [cvtf_pkg::COUNT_BITS-1:0]    hit_ff [cvtf_pkg::COLUMN_TOTAL];
   logic [cvtf_pkg::COUNT_BITS-1:0]    hit_in [cvtf_pkg::COLUMN_TOTAL];
   logic [cvtf_pkg::COLUMN_TOTAL-1:0]  act_ff;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0]  act_in;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0]  report_ff;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0]  report_in;
   logic [cvtf_pkg::COUNT_BITS-1:0]    rows_ff;
   logic [cvtf_pkg::COUNT_BITS-1:0]    rows_in;
   logic [cvtf_pkg::COUNT_BITS-1:0]    base_hit [cvtf_pkg::COLUMN_TOTAL];
   logic [cvtf_pkg::COUNT_BITS-1:0]    next_hit [cvtf_pkg::COLUMN_TOTAL];
   logic [cvtf_pkg::COUNT_BITS-1:0]    missed   [cvtf_pkg::COLUMN_TOTAL];
   logic [cvtf_pkg::COLUMN_TOTAL-1:0]  base_act;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0]  hit_now;
   logic [cvtf_pkg::COUNT_BITS-1:0]    base_rows;
   logic                               past_window;

   assign pop             = (state_ff == S_IDLE) && pop_valid;
   assign emit_load.valid = (state_ff == S_HAND) && emit_ready;
   assign emit_load.mask  = report_ff;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      hit_in    = hit_ff;
      act_in    = act_ff;
      report_in = report_ff;
      rows_in   = rows_ff;

      // first_row starts the query from a clean slate
      base_rows   = cur_ff.first_row ? '0 : rows_ff;
      past_window = {{(cvtf_pkg::CMP_BITS-cvtf_pkg::COUNT_BITS){1'b0}}, rows_ff} >
                    {{(cvtf_pkg::CMP_BITS-cvtf_pkg::CFG_BITS){1'b0}}, max_missing};
      for (int j = 0; j < cvtf_pkg::COLUMN_TOTAL; j++) begin
         base_hit[j] = cur_ff.first_row ? '0 : hit_ff[j];
         base_act[j] = cur_ff.first_row || act_ff[j];
         hit_now[j]  = base_act[j] && cur_ff.bits[j];
         next_hit[j] = (hit_now[j] && base_hit[j] != cvtf_pkg::CNT_MAX) ?
                       base_hit[j] + 1'b1 : base_hit[j];
         missed[j]   = (rows_ff > hit_ff[j]) ? rows_ff - hit_ff[j] : '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               cur_in   = pop_item;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            for (int j = 0; j < cvtf_pkg::COLUMN_TOTAL; j++) begin
               hit_in[j]    = next_hit[j];
               report_in[j] = hit_now[j] &&
                  ({{(cvtf_pkg::CMP_BITS-cvtf_pkg::COUNT_BITS){1'b0}}, next_hit[j]} >=
                   {{(cvtf_pkg::CMP_BITS-cvtf_pkg::CFG_BITS){1'b0}}, min_discovered});
               act_in[j]    = base_act[j] && !report_in[j];
            end
            rows_in  = (base_rows == cvtf_pkg::CNT_MAX) ? base_rows : base_rows + 1'b1;
            state_in = S_RETIRE;
         end
         S_RETIRE: begin
            // columns that missed too many rows can no longer make it
            if (past_window) begin
               for (int j = 0; j < cvtf_pkg::COLUMN_TOTAL; j++) begin
                  if ({{(cvtf_pkg::CMP_BITS-cvtf_pkg::COUNT_BITS){1'b0}}, missed[j]} >
                      {{(cvtf_pkg::CMP_BITS-cvtf_pkg::CFG_BITS){1'b0}}, max_missing}) begin
                     act_in[j] = 1'b0;
                  end
               end
            end
            state_in = S_HAND;
         end
         S_HAND: begin
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= '1;
         rows_ff  <= '0;
         for (int j = 0; j < cvtf_pkg::COLUMN_TOTAL; j++) begin
            hit_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         rows_ff  <= rows_in;
         hit_ff   <= hit_in;
      end
      cur_ff    <= cur_in;
      report_ff <= report_in;
   end

endmodule

@@ hw/rtl/cvtf_emit.sv @@
// Result serializer: one reported column per cycle unless rsp_ready stalls it, lowest index first.
module cvtf_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  cvtf_pkg::emit_load_type emit_load,
   output logic                    emit_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cvtf_pkg::rsp_item_type  rsp_data
);

   logic [cvtf_pkg::COLUMN_TOTAL-1:0] pend_ff;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0] pend_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   cvtf_pkg::rsp_item_type            rsp_data_ff;
   cvtf_pkg::rsp_item_type            rsp_data_in;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0] lowest;
   logic [cvtf_pkg::COLUMN_TOTAL-1:0] rest;
   logic [cvtf_pkg::COL_IDX_BITS-1:0] index;
   logic                              slot_free;

   assign emit_ready = pend_ff == '0;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      lowest = pend_ff & (~pend_ff + 1'b1);
      rest   = pend_ff & ~lowest;
      index  = '0;
      for (int j = 0; j < cvtf_pkg::COLUMN_TOTAL; j++) begin
         if (lowest[j]) begin
            index = index | cvtf_pkg::COL_IDX_BITS'(j);
         end
      end

      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_load.valid) begin
         pend_in = emit_load.mask;
      end
      if (slot_free) begin
         rsp_valid_in = pend_ff != '0;
         if (pend_ff != '0) begin
            rsp_data_in.column_index = index;
            rsp_data_in.last_of_row  = rest == '0;
            pend_in                  = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hw/rtl/cvtf_checker.sv @@
// Port-level checker for the column vote filter, bound to the top level.
`include "column_vote_threshold_filter_macros.svh"

module cvtf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cvtf_pkg::rsp_item_type rsp_data,
   input logic                   pready
);

   // a stalled result holds
   `CVTF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // no result right after reset
   `CVTF_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   // within one row, results follow back to back in ascending column order
   `CVTF_ASSERT_NEXT(a_row_ascending, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_of_row, rsp_valid && (rsp_data.column_index > $past(rsp_data.column_index)))

   `CVTF_ASSERT_ALWAYS(a_pready_high, clock, reset, pready)

endmodule

bind column_vote_threshold_filter cvtf_checker u_checker (.*);
